// ----- sv/html_entity_decoder_core_assert.svh -----
// Assertion macros shared by the entity decoder RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef HTML_ENTITY_DECODER_CORE_ASSERT_SVH
`define HTML_ENTITY_DECODER_CORE_ASSERT_SVH

// Invariant checked at every clock edge outside reset.
`define HED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a property in the next.
`define HED_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

// ----- sv/hed_pkg.sv -----
// Shared types and constants for the HTML entity decoder.
// No dependencies; imported by all decoder modules.
package hed_pkg;

  localparam int unsigned HOLD_MAX = 5;  // longest proper entity prefix
  localparam int unsigned JOB_MAX  = 6;  // most output beats per input beat
  localparam int unsigned ENT_NUM  = 5;
  localparam int unsigned CNT_W    = $clog2(JOB_MAX + 1);

  localparam logic [7:0] AMP_CHAR = 8'h26;

  typedef logic [CNT_W-1:0] cnt_t;

  // Entity spellings, zero padded to JOB_MAX bytes.
  localparam logic [7:0] ENT_TEXT [ENT_NUM][JOB_MAX] = '{
    '{"&", "q", "u", "o", "t", ";"},
    '{"&", "a", "p", "o", "s", ";"},
    '{"&", "l", "t", ";", 8'h00, 8'h00},
    '{"&", "g", "t", ";", 8'h00, 8'h00},
    '{"&", "a", "m", "p", ";", 8'h00}
  };
  localparam cnt_t ENT_LEN [ENT_NUM] = '{cnt_t'(6), cnt_t'(6), cnt_t'(4), cnt_t'(4),
                                         cnt_t'(5)};
  localparam logic [7:0] ENT_DEC [ENT_NUM] = '{8'h22, 8'h27, 8'h3c, 8'h3e, 8'h26};

  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       ends_line;
  } out_t;

  // One emit job: chars[0 .. cnt-1] go out in order, eol marks the last.
  typedef struct packed {
    logic [JOB_MAX-1:0][7:0] chars;
    cnt_t                    cnt;
    logic                    eol;
  } job_t;

  // Front-to-queue write request.
  typedef struct packed {
    logic push;
    job_t job;
  } job_req_t;

endpackage

// ----- sv/hed_front.sv -----
// Front end: accepts input beats, matches held prefix against entities,
// builds emit jobs. Depends on hed_pkg and the assertion header.
`include "html_entity_decoder_core_assert.svh"

module hed_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  hed_pkg::in_t     in_data_i,
  input  logic             q_full_i,
  output logic             in_stall_o,
  output hed_pkg::job_req_t req_o
);
  import hed_pkg::*;

  logic [7:0] held_q [HOLD_MAX];
  logic [7:0] held_d [HOLD_MAX];
  cnt_t       cnt_q, cnt_d;

  logic [7:0]         cand [JOB_MAX];
  logic [ENT_NUM-1:0] pre, full;
  logic [7:0]         dec;
  logic               accept;
  job_t               job;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // candidate = held bytes followed by the new byte
  always_comb begin
    for (int i = 0; i < HOLD_MAX; i++) begin
      cand[i] = (cnt_t'(i) < cnt_q) ? held_q[i] : in_data_i.text_byte;
    end
    cand[HOLD_MAX] = in_data_i.text_byte;
  end

  always_comb begin
    dec = '0;
    for (int e = 0; e < ENT_NUM; e++) begin
      pre[e] = cnt_q < ENT_LEN[e];
      for (int i = 0; i < JOB_MAX; i++) begin
        if (cnt_t'(i) <= cnt_q && cand[i] != ENT_TEXT[e][i]) begin
          pre[e] = 1'b0;
        end
      end
      full[e] = pre[e] && (cnt_q + cnt_t'(1) == ENT_LEN[e]);
      if (full[e]) begin
        dec = dec | ENT_DEC[e];
      end
    end
  end

  always_comb begin
    held_d = held_q;
    cnt_d  = cnt_q;
    for (int i = 0; i < JOB_MAX; i++) begin
      job.chars[i] = cand[i];
    end
    job.cnt = '0;
    job.eol = in_data_i.line_end;
    if (|full) begin
      job.chars[0] = dec;
      job.cnt      = cnt_t'(1);
      cnt_d        = '0;
    end else if (|pre && cnt_q < cnt_t'(HOLD_MAX)) begin
      for (int i = 0; i < HOLD_MAX; i++) begin
        if (cnt_t'(i) == cnt_q) begin
          held_d[i] = in_data_i.text_byte;
        end
      end
      cnt_d = cnt_q + cnt_t'(1);
      if (in_data_i.line_end) begin
        job.cnt = cnt_q + cnt_t'(1);
        cnt_d   = '0;
      end
    end else begin
      // mismatch: flush held bytes, then re-examine the new byte alone
      job.cnt = cnt_q;
      cnt_d   = '0;
      if (in_data_i.text_byte != AMP_CHAR || in_data_i.line_end) begin
        job.cnt = cnt_q + cnt_t'(1);
      end else begin
        held_d[0] = in_data_i.text_byte;
        cnt_d     = cnt_t'(1);
      end
    end
  end

  assign req_o.push = accept && (job.cnt != '0);
  assign req_o.job  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

  `HED_ASSERT(a_held_range, cnt_q <= cnt_t'(HOLD_MAX), "held count out of range")

endmodule

// ----- sv/hed_queue.sv -----
// Two-entry job queue between front end and emitter.
// Depends on hed_pkg and the assertion header.
`include "html_entity_decoder_core_assert.svh"

module hed_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hed_pkg::job_req_t req_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              head_valid_o,
  output hed_pkg::job_t     head_o
);
  import hed_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign full_o       = cnt_q == 2'd2;
  assign head_valid_o = cnt_q != 2'd0;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (req_i.push && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!req_i.push && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (req_i.push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem_q[wr_ptr_q] <= req_i.job;
    end
  end

  `HED_ASSERT(a_no_overflow, !(req_i.push && full_o), "push into full queue")
  `HED_ASSERT(a_no_underflow, !(pop_i && !head_valid_o), "pop from empty queue")

endmodule

// ----- sv/hed_back.sv -----
// Emitter: walks the head job one byte per cycle into the output register while out_stall_i is low.
// Depends on hed_pkg and the assertion header.
`include "html_entity_decoder_core_assert.svh"

module hed_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  hed_pkg::job_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output hed_pkg::out_t out_data_o
);
  import hed_pkg::*;

  cnt_t idx_q, idx_d;
  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;
  logic load, last;

  assign load  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign last  = idx_q == head_i.cnt - cnt_t'(1);
  assign pop_o = load && last;

  always_comb begin
    idx_d             = idx_q;
    out_valid_d       = out_valid_q && out_stall_i;
    out_d.out_byte    = head_i.chars[idx_q];
    out_d.last_of_run = last;
    out_d.ends_line   = last && head_i.eol;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = last ? '0 : idx_q + cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `HED_ASSERT(a_idx_range, !head_valid_i || idx_q < head_i.cnt, "emit index past job end")
  `HED_ASSERT(a_eol_last, !out_valid_q || !out_q.ends_line || out_q.last_of_run,
              "line end on non-final beat")

endmodule

// ----- sv/html_entity_decoder_core.sv -----
// HTML entity decoder core: decodes &quot; &apos; &lt; &gt; &amp; in a byte stream.
// Top level; instantiates hed_front, hed_queue and hed_back; uses hed_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): one text byte per beat,
//   with line_end set on the last byte of a line. Bytes that may still start an
//   entity are held; a full entity yields its single decoded character, a
//   mismatch flushes the held bytes unchanged, and line_end flushes everything.
//   Output channel (out_valid_o / out_stall_i / out_data_o): zero to six beats
//   per input beat. last_of_run marks the final output beat of an input beat;
//   ends_line additionally marks it when that input beat ended a line.
//   Path: a beat with output goes through a job queue write, then an output
//   register load. Throughput: one input beat per cycle while each beat yields
//   at most one output beat and out_stall_i is low; a beat producing several
//   outputs holds the emitter until all are out, since the emitter drives one
//   byte per cycle from the head of the job queue while out_stall_i is low.
//   Stall: out_stall_i freezes the output register; the two-entry job queue
//   keeps the front end accepting until it fills, then in_stall_o rises.
//   Reset (rst_ni, async low) empties the hold buffer, queue and output register.
module html_entity_decoder_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  hed_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output hed_pkg::out_t out_data_o
);
  import hed_pkg::*;

  job_req_t req;
  job_t     head;
  logic     q_full, head_valid, pop;

  // classify beats, keep the hold buffer, build emit jobs
  hed_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .req_o      (req)
  );

  // decouples front end from emitter stalls
  hed_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // one output beat per cycle from the head job while out_stall_i is low
  hed_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ----- bench/tb_html_entity_decoder_core.sv -----
// Self-checking bench for html_entity_decoder_core: random text beats, entity decode predicted.
// Depends on hed_pkg (in_t, out_t) and the decoder RTL; needs no files or arguments.
module tb_html_entity_decoder_core;
  import hed_pkg::in_t;
  import hed_pkg::out_t;

  // Longest proper entity prefix the block may hold.
  localparam int HOLD_DEPTH = 5;
  localparam int ENTITY_NUM = 5;
  localparam logic [7:0] AMP = "&";

  // Outcome of matching the held bytes plus the new byte against the entity set.
  typedef enum int {NO_MATCH, PARTIAL, WHOLE} match_e;

  // Entity spellings and the character each one decodes to, same order.
  string entity_text [ENTITY_NUM] = '{"&quot;", "&apos;", "&lt;", "&gt;", "&amp;"};
  localparam logic [7:0] ENTITY_CHAR [ENTITY_NUM] = '{"\"", "'", "<", ">", "&"};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  // Text beats waiting to go in, and decoded beats due to come out.
  in_t text_to_send [$];
  out_t decoded_due [$];

  // Predictor state: the pending entity candidate.
  logic [7:0] held_bytes [HOLD_DEPTH];
  int held_cnt = 0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_off = 1'b0;    // sender pause, set from the sequencing block
  bit beat_taken = 1'b0;  // input beat accepted at the last rising edge
  int fail_count = 0;

  html_entity_decoder_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    fail_count++;
  endtask

  // Classify cand[0 .. len-1]: no entity prefix, proper prefix, or whole entity.
  function automatic match_e match_entity(input logic [7:0] cand [HOLD_DEPTH+1], input int len,
                                          output logic [7:0] dec);
    match_e res;
    bit same;
    int e;
    int i;
    res = NO_MATCH;
    dec = 8'h00;
    for (e = 0; e < ENTITY_NUM; e++) begin
      if (len <= entity_text[e].len()) begin
        same = 1'b1;
        for (i = 0; i < len; i++) begin
          if (cand[i] != entity_text[e][i]) same = 1'b0;
        end
        if (same && len == entity_text[e].len()) begin
          dec = ENTITY_CHAR[e];
          return WHOLE;
        end
        if (same) res = PARTIAL;
      end
    end
    return res;
  endfunction

  // Advance the predictor by one accepted text beat; queue the beats it yields.
  function automatic void decode_beat(in_t beat);
    logic [7:0] cand [HOLD_DEPTH+1];
    logic [7:0] emit [$];
    logic [7:0] dec;
    match_e m;
    out_t res;
    int n;
    int i;
    n = held_cnt;
    for (i = 0; i < n; i++) cand[i] = held_bytes[i];
    cand[n] = beat.text_byte;
    m = match_entity(cand, n + 1, dec);
    if (m == WHOLE) begin
      emit.push_back(dec);
      held_cnt = 0;
    end else if (m == PARTIAL && n < HOLD_DEPTH) begin
      held_bytes[n] = beat.text_byte;
      held_cnt = n + 1;
    end else begin
      // Mismatch: flush the candidate as is, then look at the new byte alone.
      for (i = 0; i < n; i++) emit.push_back(held_bytes[i]);
      held_cnt = 0;
      if (beat.text_byte == AMP) begin
        held_bytes[0] = AMP;
        held_cnt = 1;
      end else begin
        emit.push_back(beat.text_byte);
      end
    end
    if (beat.line_end) begin
      for (i = 0; i < held_cnt; i++) emit.push_back(held_bytes[i]);
      held_cnt = 0;
    end
    for (i = 0; i < emit.size(); i++) begin
      res.out_byte = emit[i];
      res.last_of_run = (i == emit.size() - 1);
      res.ends_line = res.last_of_run & beat.line_end;
      decoded_due.push_back(res);
    end
  endfunction

  // Sender and receiver: inputs change on the falling edge only.
  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < rx_idle_pct);
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || beat_taken) begin
      // A beat once offered stays put until taken.
      beat_taken = 1'b0;
      if (!hold_off && text_to_send.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i <= text_to_send[0];
      end else begin
        in_valid_i <= 1'b0;
        in_data_i <= in_t'($urandom);
      end
    end
  end

  // Monitor: both handshakes sampled at the rising edge.
  always @(posedge clk_i) begin : monitor
    out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        decode_beat(text_to_send.pop_front());
        beat_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (decoded_due.size() == 0) begin
          report_mismatch("unexpected out_byte", out_data_o.out_byte, 0);
        end else begin
          want = decoded_due.pop_front();
          if (out_data_o.out_byte !== want.out_byte)
            report_mismatch("out_byte", out_data_o.out_byte, want.out_byte);
          if (out_data_o.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", out_data_o.last_of_run, want.last_of_run);
          if (out_data_o.ends_line !== want.ends_line)
            report_mismatch("ends_line", out_data_o.ends_line, want.ends_line);
        end
      end
    end
  end

  task automatic add_byte(logic [7:0] b, bit eol);
    in_t beat;
    beat.text_byte = b;
    beat.line_end = eol;
    text_to_send.push_back(beat);
  endtask

  task automatic add_text(string s, bit eol_last);
    int i;
    for (i = 0; i < s.len(); i++) add_byte(s[i], eol_last && i == s.len() - 1);
  endtask

  function automatic bit coin(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Mostly well-formed entities and near misses with random content, some raw noise.
  // Each run ends on a line end so nothing stays held across phases.
  task automatic add_random_run(int count);
    int stop;
    int kind;
    int e;
    int k;
    string s;
    stop = text_to_send.size() + count;
    while (text_to_send.size() < stop) begin
      kind = $urandom_range(99);
      e = $urandom_range(ENTITY_NUM - 1);
      s = entity_text[e];
      if (kind < 35) begin
        add_text(s, coin(12));
      end else if (kind < 55) begin
        // Truncated candidate, then a byte that usually breaks it.
        k = $urandom_range(s.len() - 1, 1);
        add_text(s.substr(0, k - 1), coin(15));
        add_byte(8'($urandom_range(255)), coin(10));
      end else if (kind < 65) begin
        // Run of ampersands in front of an entity.
        repeat ($urandom_range(3, 1)) add_byte(AMP, 1'b0);
        add_text(s.substr(1, s.len() - 1), coin(10));
      end else if (kind < 73) begin
        // Decoded ampersand must not start a second decode.
        add_text({"&amp;", s.substr(1, s.len() - 1)}, coin(10));
      end else if (kind < 90) begin
        add_byte(8'($urandom_range(255)), coin(10));
      end else begin
        add_byte(8'($urandom_range("z", "a")), coin(10));
      end
    end
    add_byte(8'($urandom_range(255)), 1'b1);
  endtask

  // Block until the sender has nothing left and every decoded beat is in.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (text_to_send.size() != 0 || in_valid_i || decoded_due.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    tx_idle_pct = 7;
    rx_idle_pct = 71;

    // Directed: byte extremes, repeated and decoded ampersand, a whole entity,
    // and a line end that lands on a held candidate.
    add_byte(8'h00, 1'b0);
    add_byte(8'hff, 1'b1);
    add_text("&&lt;", 1'b0);
    add_text("&amp;lt;", 1'b0);
    add_text("&quot;", 1'b1);
    add_text("&ap", 1'b1);
    add_random_run(70);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    wait_idle();

    @(posedge clk_i);
    tx_idle_pct = 71;
    rx_idle_pct = 7;
    add_random_run(40);

    // Sender backs off mid-stream until the output side is drained.
    do @(negedge clk_i);
    while (text_to_send.size() >= 10);
    @(posedge clk_i) hold_off = 1'b1;
    do @(negedge clk_i);
    while (in_valid_i || decoded_due.size() != 0);
    @(posedge clk_i) hold_off = 1'b0;
    add_random_run(35);
    wait_idle();

    @(posedge clk_i);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    add_random_run(70);
    wait_idle();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule
